### design/nlc_pkg.sv
// Shared types, character codes and limits of the numeric literal classifier.
`default_nettype none

package nlc_pkg;

    localparam int MAX_SIG_DIGITS = 8;
    localparam int CNT_W          = 5;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_PLUS = 8'h2b;
    localparam logic [7:0] CH_MIN  = 8'h2d;
    localparam logic [7:0] CH_DOT  = 8'h2e;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_7    = 8'h37;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_E    = 8'h65;
    localparam logic [7:0] CH_F    = 8'h66;
    localparam logic [7:0] CH_X    = 8'h78;

    // Result flags; hex_ok sits in the lowest bit when packed.
    typedef struct packed {
        logic float_ok;
        logic dec_ok;
        logic oct_ok;
        logic hex_ok;
    } t_flags;

    typedef struct packed {
        logic [1:0]       pos;
        logic             hex_alive;
        logic             oct_alive;
        logic             dec_alive;
        logic             dec_digit;
        logic             f_rejected;
        logic             f_stopped;
        logic             seen_dot;
        logic             seen_exp;
        logic             seen_digit;
        logic             sign_skip;
        logic [CNT_W-1:0] sig_cnt;
        logic [CNT_W-1:0] pend_zeros;
    } t_scan_state;

    localparam t_scan_state SCAN_IDLE = '{
        pos: 2'd0, hex_alive: 1'b1, oct_alive: 1'b1, dec_alive: 1'b1,
        dec_digit: 1'b0, f_rejected: 1'b0, f_stopped: 1'b0, seen_dot: 1'b0,
        seen_exp: 1'b0, seen_digit: 1'b0, sign_skip: 1'b0,
        sig_cnt: '0, pend_zeros: '0
    };

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b,
                                                   input logic             inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b} + {{CNT_W{1'b0}}, inc};
        return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

### design/numeric_literal_classifier.sv
// Numeric literal classifier top level: stream handshakes and result register.
//
// The block reads a word one character per item on the slave channel
// (i_s_tvalid / o_s_tready / i_s_tdata). A zero byte ends the word and the
// next character starts a new one. For each ending zero byte one item leaves
// on the master channel (o_m_tvalid / i_m_tready / o_m_tdata) carrying four
// flags: hex, octal, decimal integer and floating-point literal. Other
// characters produce no result.
// Throughput is one character per cycle: the word state is updated by a
// short block of logic in the cycle the character is accepted. The result
// appears in the cycle after its zero byte is accepted, from the result register.
// A waiting result does not stop input as long as the receiver takes it in
// the same cycle; if the receiver stalls with a result held, o_s_tready
// drops until that result is taken, so nothing is lost.
// A synchronous reset (i_rst_n low) clears the result valid flag and puts the
// scanner at the start of a new word.
`default_nettype none

module numeric_literal_classifier
    import nlc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] ch
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata    // [0] hex_ok, [1] oct_ok, [2] dec_ok,
                                         // [3] float_ok, [7:4] zero
);

    t_flags flags;
    t_flags r_flags;
    logic   word_end;
    logic   accept;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    nlc_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_ch       (i_s_tdata),
        .o_flags    (flags),
        .o_word_end (word_end)
    );

    always_comb begin
        if (word_end) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (word_end) begin
            r_flags <= flags;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_flags};

    // A new result only follows an accepted zero byte.
    a_result_from_word_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !$past(o_m_tvalid)) |-> $past(accept && (i_s_tdata == CH_NUL)))
        else $error("result appeared without an ending zero byte");

    // A result that is still held never allows input.
    a_no_input_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while a result is stalled");

    // An octal literal is always a decimal integer too.
    a_oct_is_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!o_m_tdata[1] || o_m_tdata[2]))
        else $error("octal word not flagged as decimal");

    // A float literal can never also be an integer literal.
    a_float_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[3]) |-> (o_m_tdata[2:0] == 3'b000))
        else $error("float flag together with an integer flag");

endmodule

`default_nettype wire

### design/nlc_scan.sv
// Per-character word scanner: holds the word state and forms the result flags.
`default_nettype none

module nlc_scan
    import nlc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_ch,
    output t_flags          o_flags,
    output logic            o_word_end
);

    t_scan_state r_st;
    t_scan_state n_st;
    t_scan_state n_adv;
    t_flags      flags;

    logic first;
    logic is_sign;
    logic is_digit;
    logic hex_ok_ch;
    logic done;
    logic upd;

    assign first    = (r_st.pos == 2'd0);
    assign is_sign  = (i_ch == CH_PLUS) || (i_ch == CH_MIN);
    assign is_digit = (i_ch >= CH_0) && (i_ch <= CH_9);

    always_comb begin
        flags.hex_ok = r_st.hex_alive && (r_st.pos == 2'd2);
        flags.oct_ok = r_st.oct_alive && (r_st.pos != 2'd0);
        flags.dec_ok = r_st.dec_alive && r_st.dec_digit;
        flags.float_ok = !r_st.f_rejected
            && !((r_st.sig_cnt == '0) && !r_st.seen_digit)
            && !(r_st.seen_exp && !r_st.seen_digit)
            && (r_st.seen_exp || r_st.seen_dot)
            && !((r_st.sig_cnt > CNT_W'(MAX_SIG_DIGITS)) && !r_st.seen_exp);
    end

    always_comb begin
        n_adv = r_st;
        done  = 1'b0;
        upd   = 1'b0;

        case (r_st.pos)
            2'd0:    hex_ok_ch = (i_ch == CH_0);
            2'd1:    hex_ok_ch = (i_ch == CH_X);
            default: hex_ok_ch = is_digit || ((i_ch >= CH_A) && (i_ch <= CH_F));
        endcase
        if (!hex_ok_ch) begin
            n_adv.hex_alive = 1'b0;
        end

        if ((i_ch < CH_0) || (i_ch > CH_7) || (first && (i_ch != CH_0))) begin
            n_adv.oct_alive = 1'b0;
        end

        if (!(first && is_sign)) begin
            if (is_digit) begin
                n_adv.dec_digit = 1'b1;
            end else begin
                n_adv.dec_alive = 1'b0;
            end
        end

        // Float check; once rejected or at the digit limit it ignores the word.
        if (!r_st.f_rejected && !r_st.f_stopped) begin
            if (r_st.sign_skip) begin
                n_adv.sign_skip = 1'b0;
                done = is_sign;
            end
            if (!done && first && is_sign) begin
                done = 1'b1;
            end
            if (!done) begin
                if (i_ch == CH_DOT) begin
                    if (r_st.seen_dot || r_st.seen_exp) begin
                        n_adv.f_rejected = 1'b1;
                    end else begin
                        n_adv.seen_dot   = 1'b1;
                        n_adv.sig_cnt    = sat_add(r_st.sig_cnt, r_st.pend_zeros, 1'b0);
                        n_adv.pend_zeros = '0;
                        upd = 1'b1;
                    end
                end else if (i_ch == CH_E) begin
                    if (r_st.seen_exp || !r_st.seen_digit) begin
                        n_adv.f_rejected = 1'b1;
                    end else begin
                        n_adv.sign_skip  = 1'b1;
                        n_adv.seen_digit = 1'b0;
                        n_adv.seen_exp   = 1'b1;
                        n_adv.sig_cnt    = '0;
                        n_adv.pend_zeros = '0;
                        upd = 1'b1;
                    end
                end else if (i_ch == CH_0) begin
                    n_adv.seen_digit = 1'b1;
                    if (r_st.sig_cnt != '0) begin
                        n_adv.pend_zeros = sat_add(r_st.pend_zeros, '0, 1'b1);
                    end
                    upd = 1'b1;
                end else if ((i_ch >= CH_1) && (i_ch <= CH_9)) begin
                    n_adv.seen_digit = 1'b1;
                    n_adv.sig_cnt    = sat_add(r_st.sig_cnt, r_st.pend_zeros, 1'b1);
                    n_adv.pend_zeros = '0;
                    upd = 1'b1;
                end else begin
                    n_adv.f_rejected = 1'b1;
                end
                if (upd && (n_adv.sig_cnt >= CNT_W'(MAX_SIG_DIGITS))) begin
                    n_adv.f_stopped = 1'b1;
                end
            end
        end

        if (r_st.pos != 2'd2) begin
            n_adv.pos = r_st.pos + 2'd1;
        end
    end

    always_comb begin
        if (!i_accept) begin
            n_st = r_st;
        end else if (i_ch == CH_NUL) begin
            n_st = SCAN_IDLE;
        end else begin
            n_st = n_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= SCAN_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_flags    = flags;
    assign o_word_end = i_accept && (i_ch == CH_NUL);

endmodule

`default_nettype wire
